// ----- design/jcs_pkg.sv -----
`default_nettype none
package jcs_pkg;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	// queue between classifier and output serializer
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// one classified item: one or two bytes to send
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       two;
		logic       last;
	} entry_t;

	// queue head as seen by the serializer
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

endpackage
`default_nettype wire

// ----- design/jcs_in_if.sv -----
`default_nettype none
interface jcs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

// ----- design/jcs_out_if.sv -----
`default_nettype none
interface jcs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

// ----- design/json_comment_stripper_unit.sv -----
`default_nettype none
// channel   dir  handshake        payload
// in_ch     in   valid / ready    text_byte[7:0], end_of_text
// out_ch    out  valid / ready    out_byte[7:0], out_last
// cfg       in   cfg_we           cfg_wdata (strip_enable, reset 1)
//
// the front classifier takes one item per cycle while its queue has room
// an item gives zero, one or two output bytes; the back drains one byte per cycle unless out_ch stalls
// so an item that gives two bytes is sent as byte0 then byte1 and leaves the queue with the second
// a 4-entry queue and the output register let either side stall alone
// arst_n clears scan state, queue pointers and output valid; strip_enable resets to 1
module json_comment_stripper_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	jcs_in_if.sink    in_ch,
	jcs_out_if.source out_ch
);
	import jcs_pkg::*;

	// front to queue
	logic   push;
	entry_t push_entry;
	logic   queue_full;

	// queue to back
	head_t  head;
	logic   pop;

	// scanner: quote, comment and held slash tracking
	jcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.text_byte   (in_ch.text_byte),
		.end_of_text (in_ch.end_of_text),
		.queue_full  (queue_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	// decouples scanner from output stalls
	jcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head       (head)
	);

	// serializes one or two bytes per entry into the output register
	jcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_byte  (out_ch.out_byte),
		.out_last  (out_ch.out_last)
	);

endmodule
`default_nettype wire

// ----- design/jcs_front.sv -----
`default_nettype none
module jcs_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     text_byte,
	input  wire logic           end_of_text,
	input  wire logic           queue_full,
	output logic                push,
	output jcs_pkg::entry_t     push_entry
);
	import jcs_pkg::*;

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_LIT   = 3'd1,
		MODE_LINE  = 3'd2,
		MODE_BLOCK = 3'd3,
		MODE_STAR  = 3'd4
	} mode_t;

	mode_t      mode_q, mode_d;
	logic       single_q, single_d;
	logic       esc_q, esc_d;
	logic       held_q, held_d;
	logic       enable_q;
	logic       accept;
	logic [1:0] n;
	logic [7:0] b0, b1;
	logic [7:0] quote;
	logic       pre_slash;
	logic       emit_b;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		mode_d    = mode_q;
		single_d  = single_q;
		esc_d     = esc_q;
		held_d    = held_q;
		n         = 2'd0;
		b0        = text_byte;
		b1        = text_byte;
		quote     = single_q ? CH_SQUOTE : CH_DQUOTE;
		pre_slash = 1'b0;
		emit_b    = 1'b0;
		if (!enable_q) begin
			if (held_q) begin
				b0     = CH_SLASH;
				n      = 2'd2;
				held_d = 1'b0;
			end else begin
				n = 2'd1;
			end
		end else begin
			case (mode_q)
				MODE_LIT: begin
					if (esc_q && text_byte == quote) begin
						esc_d = 1'b0;
					end else if (text_byte == quote) begin
						esc_d  = 1'b0;
						mode_d = MODE_PLAIN;
					end else begin
						esc_d = (text_byte == CH_BSLASH);
					end
					n = 2'd1;
				end
				MODE_LINE: begin
					if (text_byte == CH_NL) begin
						mode_d = MODE_PLAIN;
					end
					b0 = CH_SPACE;
					n  = 2'd1;
				end
				MODE_BLOCK: begin
					if (text_byte == CH_STAR) begin
						mode_d = MODE_STAR;
					end
					b0 = CH_SPACE;
					n  = 2'd1;
				end
				MODE_STAR: begin
					if (text_byte == CH_SLASH) begin
						mode_d = MODE_PLAIN;
					end else if (text_byte != CH_STAR) begin
						mode_d = MODE_BLOCK;
					end
					b0 = CH_SPACE;
					n  = 2'd1;
				end
				default: begin
					// plain text, also any code that means nothing
					mode_d = MODE_PLAIN;
					if (held_q && (text_byte == CH_STAR || text_byte == CH_SLASH)) begin
						held_d = 1'b0;
						b0     = CH_SPACE;
						b1     = CH_SPACE;
						n      = 2'd2;
						mode_d = (text_byte == CH_STAR) ? MODE_BLOCK : MODE_LINE;
					end else begin
						pre_slash = held_q;
						held_d    = 1'b0;
						if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE) begin
							mode_d   = MODE_LIT;
							single_d = (text_byte == CH_SQUOTE);
							esc_d    = 1'b0;
							emit_b   = 1'b1;
						end else if (text_byte == CH_SLASH) begin
							held_d = 1'b1;
						end else begin
							emit_b = 1'b1;
						end
						if (pre_slash) begin
							b0 = CH_SLASH;
							n  = emit_b ? 2'd2 : 2'd1;
						end else begin
							n = emit_b ? 2'd1 : 2'd0;
						end
					end
				end
			endcase
		end
		// end of text flushes a held slash
		if (end_of_text && held_d) begin
			if (n == 2'd0) begin
				b0 = CH_SLASH;
				n  = 2'd1;
			end else begin
				b1 = CH_SLASH;
				n  = 2'd2;
			end
		end
	end

	assign push             = accept && (n != 2'd0);
	assign push_entry.byte0 = b0;
	assign push_entry.byte1 = b1;
	assign push_entry.two   = (n == 2'd2);
	assign push_entry.last  = end_of_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			single_q <= 1'b0;
			esc_q    <= 1'b0;
			held_q   <= 1'b0;
			enable_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			if (accept) begin
				if (end_of_text) begin
					mode_q   <= MODE_PLAIN;
					single_q <= 1'b0;
					esc_q    <= 1'b0;
					held_q   <= 1'b0;
				end else begin
					mode_q   <= mode_d;
					single_q <= single_d;
					esc_q    <= esc_d;
					held_q   <= held_d;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/jcs_queue.sv -----
`default_nettype none
module jcs_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire jcs_pkg::entry_t push_entry,
	output logic                 full,
	input  wire logic            pop,
	output jcs_pkg::head_t       head
);
	import jcs_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/jcs_back.sv -----
`default_nettype none
module jcs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire jcs_pkg::head_t head,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last
);
	import jcs_pkg::*;

	logic       phase_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       load;
	logic       final_byte;

	assign load       = !valid_q || out_ready;
	assign final_byte = !head.entry.two || phase_q;
	assign pop        = load && head.valid && final_byte;
	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign out_last   = last_q;

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			byte_q <= phase_q ? head.entry.byte1 : head.entry.byte0;
			last_q <= head.entry.last && final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= head.valid;
			if (head.valid) begin
				phase_q <= !final_byte;
			end
		end
	end

endmodule
`default_nettype wire
